// ===== sv/ipd_pkg.sv =====
// Package for the incremental PID duty update block.
// Holds widths, fixed-point constants, register codes and item types.
// No dependencies; every other file of the block imports it.
package ipd_pkg;

    localparam int DUTY_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int ERR_FRAC_BITS  = 8;

    localparam int DATA_W = 16;
    localparam int ERR_W  = DATA_W + 1;
    localparam int GAIN_W = 32;
    localparam int INC_W  = 32;
    localparam int DUTY_W = 16;
    localparam int CFG_W  = 32;

    localparam int PROD_W  = ERR_W + GAIN_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int RESCALE = ERR_FRAC_BITS + GAIN_FRAC_BITS - DUTY_FRAC_BITS;

    // Exact unsigned division by ten for 32-bit values: (x * RECIP) >> RECIP_SHIFT.
    localparam logic [INC_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               RPROD_W     = 2 * INC_W;
    localparam int               QMAG_W      = RPROD_W - RECIP_SHIFT;
    localparam int               Q_W         = QMAG_W + 1;
    localparam int               CAND_W      = Q_W + 1;

    localparam int DUTY_LIMIT = (DUTY_FRAC_BITS < DUTY_W) ? (1 << DUTY_FRAC_BITS)
                                                          : (1 << DUTY_W);

    localparam logic signed [GAIN_W-1:0] GAIN_CURRENT_RESET = 32'sd67109;
    localparam logic [DUTY_W-1:0]        START_DUTY_RESET   = 16'd32768;

    // Queue depths must be powers of two so that the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUTQ_DEPTH  = 2;
    localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW     = $clog2(OUTQ_DEPTH + 1);

    localparam int N_STAGES = 5;

    typedef enum logic [1:0] {
        CFG_GAIN_CURRENT,
        CFG_GAIN_PREVIOUS,
        CFG_GAIN_BEFORE_PREVIOUS,
        CFG_START_DUTY
    } t_cfg_index;

    typedef struct packed {
        logic signed [GAIN_W-1:0] g_current;
        logic signed [GAIN_W-1:0] g_previous;
        logic signed [GAIN_W-1:0] g_before_previous;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } t_err_item;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic                    accepted;
        logic signed [INC_W-1:0] increment;
    } t_result;

endpackage

// ===== sv/ipd_front.sv =====
// Front end of the incremental PID duty update block.
// Accepts ticks, forms the error and keeps the error history; depends on ipd_pkg.
module ipd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  logic [ipd_pkg::DATA_W-1:0] i_setpoint,
    input  logic [ipd_pkg::DATA_W-1:0] i_measured,
    input  logic                      i_queue_full,
    output logic                      o_wr_en,
    output ipd_pkg::t_err_item        o_wr_item
);
    import ipd_pkg::*;

    logic signed [ERR_W-1:0] r_e1, n_e1;
    logic signed [ERR_W-1:0] r_e2, n_e2;
    logic signed [ERR_W-1:0] w_e0;

    assign w_e0    = $signed({1'b0, i_setpoint}) - $signed({1'b0, i_measured});
    assign o_wr_en = push && !i_queue_full;

    always_comb begin
        o_wr_item.e0 = w_e0;
        o_wr_item.e1 = r_e1;
        o_wr_item.e2 = r_e2;
        n_e1 = r_e1;
        n_e2 = r_e2;
        if (o_wr_en) begin
            n_e1 = w_e0;
            n_e2 = r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

endmodule

// ===== sv/ipd_queue.sv =====
// Short queue of error items between the front and back ends.
// Register array with wrapping pointers and a fill count; depends on ipd_pkg.
module ipd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  ipd_pkg::t_err_item i_wr_item,
    output logic               o_full,
    input  logic               i_rd_en,
    output ipd_pkg::t_err_item o_rd_item,
    output logic               o_empty
);
    import ipd_pkg::*;

    t_err_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;

    assign o_full    = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/ipd_back.sv =====
// Back end of the incremental PID duty update block.
// Multiply, sum, rescale, divide by ten, update the duty and queue the result.
// Depends on ipd_pkg.
module ipd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipd_pkg::t_gains    i_gains,
    input  logic               i_queue_empty,
    input  ipd_pkg::t_err_item i_queue_item,
    output logic               o_queue_rd,
    output logic               empty,
    input  logic               pop,
    output ipd_pkg::t_result   o_result
);
    import ipd_pkg::*;

    logic                       w_en;
    logic                       w_oq_wr;
    logic [N_STAGES-1:0]        r_valid, n_valid;

    logic signed [PROD_W-1:0]   r_s1_p0, r_s1_p1, r_s1_p2;
    logic signed [SUM_W-1:0]    w_sum, w_shifted;
    logic [SUM_W-INC_W:0]       w_top;
    logic signed [INC_W-1:0]    w_sat;
    logic signed [INC_W-1:0]    r_s2_inc, r_s3_inc, r_s4_inc, r_s5_inc;
    logic [INC_W-1:0]           r_s3_mag;
    logic                       r_s3_neg, r_s4_neg;
    logic [RPROD_W-1:0]         r_s4_prod;
    logic [QMAG_W-1:0]          w_qmag;
    logic signed [Q_W-1:0]      r_s5_q;
    logic signed [CAND_W-1:0]   w_cand;
    logic                       w_ok;
    logic [DUTY_W-1:0]          r_duty, n_duty;

    t_result                    r_oq [OUTQ_DEPTH];
    t_result                    w_res;
    logic [OUTQ_AW-1:0]         r_oq_wr_ptr, r_oq_rd_ptr;
    logic [OUTQ_CW-1:0]         r_oq_count, n_oq_count;
    logic                       w_pop;

    localparam logic signed [CAND_W-1:0] LIMIT = CAND_W'(DUTY_LIMIT);

    assign w_pop      = pop && !empty;
    assign w_en       = (r_oq_count != OUTQ_CW'(OUTQ_DEPTH)) || w_pop;
    assign o_queue_rd = w_en && !i_queue_empty;
    assign w_oq_wr    = w_en && r_valid[N_STAGES-1];
    assign n_valid    = {r_valid[N_STAGES-2:0], o_queue_rd};

    assign w_sum     = {{2{r_s1_p0[PROD_W-1]}}, r_s1_p0} - {{2{r_s1_p1[PROD_W-1]}}, r_s1_p1}
                     + {{2{r_s1_p2[PROD_W-1]}}, r_s1_p2};
    assign w_shifted = w_sum >>> RESCALE;
    assign w_top     = w_shifted[SUM_W-1:INC_W-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_sat = w_shifted[INC_W-1:0];
        end else if (w_shifted[SUM_W-1]) begin
            w_sat = {1'b1, {(INC_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(INC_W-1){1'b1}}};
        end
    end

    assign w_qmag = r_s4_prod[RPROD_W-1:RECIP_SHIFT];
    assign w_cand = $signed({{(CAND_W-DUTY_W){1'b0}}, r_duty})
                  + $signed({r_s5_q[Q_W-1], r_s5_q});
    assign w_ok   = (w_cand > 0) && (w_cand < LIMIT);

    always_comb begin
        n_duty = r_duty;
        if (w_oq_wr && w_ok) begin
            n_duty = w_cand[DUTY_W-1:0];
        end
        w_res.duty      = n_duty;
        w_res.accepted  = w_ok;
        w_res.increment = r_s5_inc;
    end

    always_comb begin
        n_oq_count = r_oq_count;
        if (w_oq_wr && !w_pop) begin
            n_oq_count = r_oq_count + 1'b1;
        end else if (!w_oq_wr && w_pop) begin
            n_oq_count = r_oq_count - 1'b1;
        end
    end

    assign empty    = (r_oq_count == '0);
    assign o_result = r_oq[r_oq_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_p0   <= i_gains.g_current * i_queue_item.e0;
            r_s1_p1   <= i_gains.g_previous * i_queue_item.e1;
            r_s1_p2   <= i_gains.g_before_previous * i_queue_item.e2;
            r_s2_inc  <= w_sat;
            r_s3_inc  <= r_s2_inc;
            r_s3_neg  <= r_s2_inc[INC_W-1];
            r_s3_mag  <= r_s2_inc[INC_W-1] ? (~r_s2_inc + 1'b1) : r_s2_inc;
            r_s4_inc  <= r_s3_inc;
            r_s4_neg  <= r_s3_neg;
            r_s4_prod <= r_s3_mag * RECIP;
            r_s5_inc  <= r_s4_inc;
            r_s5_q    <= r_s4_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
        end
        if (w_oq_wr) begin
            r_oq[r_oq_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_duty      <= START_DUTY_RESET;
            r_oq_wr_ptr <= '0;
            r_oq_rd_ptr <= '0;
            r_oq_count  <= '0;
        end else begin
            if (w_en) begin
                r_valid <= n_valid;
            end
            r_duty     <= n_duty;
            r_oq_count <= n_oq_count;
            if (w_oq_wr) begin
                r_oq_wr_ptr <= r_oq_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_oq_rd_ptr <= r_oq_rd_ptr + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_count <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_valid) && $stable(r_duty)
                   && (!r_valid[N_STAGES-1] || $stable(r_s5_q))))
        else $error("Pipeline moved while the result queue was full.");

    a_duty_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_oq_wr && w_ok) |=> (r_duty != '0))
        else $error("Accepted duty is zero.");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_queue_rd |-> !i_queue_empty)
        else $error("Error item read from an empty queue.");
`endif

endmodule

// ===== sv/incremental_pid_duty_update.sv =====
// Top level of the incremental PID duty update block: one item per cycle sustained while the
// result queue is not held full. An accepted item passes the queue and the five-stage back end
// (multiply, sum and saturate, magnitude, divide-by-ten multiply, quotient) to its result.
// Reset is synchronous: gains and errors take their reset values, duty is 32768,
// and both queues empty. Depends on ipd_pkg, ipd_front, ipd_queue and ipd_back.
module incremental_pid_duty_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [ipd_pkg::DATA_W-1:0] i_setpoint,
    input  logic [ipd_pkg::DATA_W-1:0] i_measured,
    output logic                       empty,
    input  logic                       pop,
    output logic [ipd_pkg::DUTY_W-1:0] o_duty,
    output logic                       o_accepted,
    output logic signed [ipd_pkg::INC_W-1:0] o_increment,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [ipd_pkg::CFG_W-1:0]  i_cfg_data
);
    import ipd_pkg::*;

    t_gains    r_gains, n_gains;
    logic      w_wr_en;
    t_err_item w_wr_item;
    logic      w_queue_full;
    logic      w_queue_empty;
    logic      w_queue_rd;
    t_err_item w_queue_item;
    t_result   w_result;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_gains = r_gains;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GAIN_CURRENT:         n_gains.g_current         = $signed(i_cfg_data);
                CFG_GAIN_PREVIOUS:        n_gains.g_previous        = $signed(i_cfg_data);
                CFG_GAIN_BEFORE_PREVIOUS: n_gains.g_before_previous = $signed(i_cfg_data);
                // A start duty write changes nothing; the duty register gets its start value only at reset.
                CFG_START_DUTY:           n_gains = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.g_current         <= GAIN_CURRENT_RESET;
            r_gains.g_previous        <= '0;
            r_gains.g_before_previous <= '0;
        end else begin
            r_gains <= n_gains;
        end
    end

    ipd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .i_queue_full (w_queue_full),
        .o_wr_en      (w_wr_en),
        .o_wr_item    (w_wr_item)
    );

    ipd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_item (w_wr_item),
        .o_full    (w_queue_full),
        .i_rd_en   (w_queue_rd),
        .o_rd_item (w_queue_item),
        .o_empty   (w_queue_empty)
    );

    ipd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gains       (r_gains),
        .i_queue_empty (w_queue_empty),
        .i_queue_item  (w_queue_item),
        .o_queue_rd    (w_queue_rd),
        .empty         (empty),
        .pop           (pop),
        .o_result      (w_result)
    );

    assign full        = w_queue_full;
    assign o_duty      = w_result.duty;
    assign o_accepted  = w_result.accepted;
    assign o_increment = w_result.increment;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for incremental_pid_duty_update: directed ticks from a table,
// then randomized gain settings and ticks, each duty update checked against the table or a predictor.
// Depends on ipd_pkg and the RTL of the block only.
module tb;
    import ipd_pkg::*;

    localparam int     RANDOM_PHASES   = 12;
    localparam int     TICKS_PER_PHASE = 100;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     DRAIN_CYCLES    = 20;
    localparam int     MAX_REPORTS     = 50;
    localparam int     N_ROWS          = 28;
    localparam longint INC_MAX         = 64'sd2147483647;
    localparam longint INC_MIN         = -64'sd2147483648;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [DATA_W-1:0]         i_setpoint;
    logic [DATA_W-1:0]         i_measured;
    logic                      empty;
    logic                      pop;
    logic [DUTY_W-1:0]         o_duty;
    logic                      o_accepted;
    logic signed [INC_W-1:0]   o_increment;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;

    incremental_pid_duty_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .empty       (empty),
        .pop         (pop),
        .o_duty      (o_duty),
        .o_accepted  (o_accepted),
        .o_increment (o_increment),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the controller: gains, start duty, error history and duty register.
    logic signed [GAIN_W-1:0] gain_cur   = GAIN_CURRENT_RESET;
    logic signed [GAIN_W-1:0] gain_prev  = '0;
    logic signed [GAIN_W-1:0] gain_prev2 = '0;
    logic [DUTY_W-1:0]        start_duty_shadow = START_DUTY_RESET;
    longint                   err_last = 0;
    longint                   err_prev = 0;
    longint                   duty_now = longint'(START_DUTY_RESET);

    t_result duty_results_due[$];

    int mismatches   = 0;
    int ticks_checked = 0;
    int taken        = 0;
    int refused      = 0;
    int at_limit     = 0;
    int reg_writes   = 0;
    bit steady       = 1'b0;
    bit hold_off_wanted = 1'b0;

    typedef struct {
        bit               is_write;
        t_cfg_index       reg_index;
        logic [CFG_W-1:0] value;
        bit               typed;
        t_result          want;
    } t_row;

    // A tick row carries {setpoint, measured} in value.
    t_row rows [N_ROWS] = '{
        '{1'b0, CFG_GAIN_CURRENT, {16'h0000, 16'h0000}, 1'b1, '{16'd32768, 1'b1, 32'sd0}},
        '{1'b1, CFG_GAIN_CURRENT, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b1, CFG_GAIN_PREVIOUS, 32'h8000_0000, 1'b0, '0},
        '{1'b1, CFG_GAIN_BEFORE_PREVIOUS, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'hFFFF, 16'h0000}, 1'b1,
          '{16'd32768, 1'b0, 32'sd2147450879}},
        '{1'b0, CFG_GAIN_CURRENT, {16'hFFFF, 16'h0000}, 1'b1,
          '{16'd32768, 1'b0, 32'sd2147483647}},
        '{1'b0, CFG_GAIN_CURRENT, {16'hFFFF, 16'h0000}, 1'b1,
          '{16'd32768, 1'b0, 32'sd2147483647}},
        '{1'b0, CFG_GAIN_CURRENT, {16'h0000, 16'hFFFF}, 1'b1,
          '{16'd32768, 1'b0, 32'sd2147450880}},
        '{1'b0, CFG_GAIN_CURRENT, {16'h0000, 16'hFFFF}, 1'b1,
          '{16'd32768, 1'b0, -32'sd2147450880}},
        '{1'b0, CFG_GAIN_CURRENT, {16'h0000, 16'hFFFF}, 1'b1,
          '{16'd32768, 1'b0, 32'sh8000_0000}},
        '{1'b1, CFG_GAIN_CURRENT, 32'h0000_0000, 1'b0, '0},
        '{1'b1, CFG_GAIN_PREVIOUS, 32'h0000_0000, 1'b0, '0},
        '{1'b1, CFG_GAIN_BEFORE_PREVIOUS, 32'h0000_0000, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'hA5A5, 16'h5A5A}, 1'b1, '{16'd32768, 1'b1, 32'sd0}},
        '{1'b1, CFG_START_DUTY, 32'h0000_0001, 1'b0, '0},
        // A gain of ten in the increment makes each tick move the duty by the error.
        '{1'b1, CFG_GAIN_CURRENT, 32'h000A_0000, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'd32767, 16'd0}, 1'b1, '{16'd65535, 1'b1, 32'sd327670}},
        '{1'b0, CFG_GAIN_CURRENT, {16'd1, 16'd0}, 1'b1, '{16'd65535, 1'b0, 32'sd10}},
        '{1'b0, CFG_GAIN_CURRENT, {16'd0, 16'd65535}, 1'b1,
          '{16'd65535, 1'b0, -32'sd655350}},
        '{1'b0, CFG_GAIN_CURRENT, {16'd0, 16'd65534}, 1'b1, '{16'd1, 1'b1, -32'sd655340}},
        '{1'b0, CFG_GAIN_CURRENT, {16'd0, 16'd1}, 1'b1, '{16'd1, 1'b0, -32'sd10}},
        '{1'b1, CFG_GAIN_PREVIOUS, 32'hFFFF_0000, 1'b0, '0},
        '{1'b1, CFG_GAIN_BEFORE_PREVIOUS, 32'h0001_2345, 1'b0, '0},
        '{1'b1, CFG_START_DUTY, 32'h0000_FFFF, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'h1234, 16'h0FED}, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'h0100, 16'h0203}, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{1'b0, CFG_GAIN_CURRENT, {16'h0000, 16'h0000}, 1'b0, '0}
    };

    function automatic t_result next_duty_result(input logic [DATA_W-1:0] sp,
                                                 input logic [DATA_W-1:0] ms);
        t_result r;
        longint  e0;
        longint  total;
        longint  inc;
        longint  cand;
        e0 = longint'(sp) - longint'(ms);
        total = longint'(gain_cur) * e0 - longint'(gain_prev) * err_last
              + longint'(gain_prev2) * err_prev;
        inc = total >>> RESCALE;
        if (inc > INC_MAX) inc = INC_MAX;
        if (inc < INC_MIN) inc = INC_MIN;
        cand = duty_now + inc / 10;
        r.accepted = (cand > 0) && (cand < DUTY_LIMIT);
        if (r.accepted) duty_now = cand;
        r.duty = duty_now[DUTY_W-1:0];
        r.increment = inc[INC_W-1:0];
        err_prev = err_last;
        err_last = e0;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        logic [CFG_W-1:0] mag;
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return $urandom();
            default: begin
                mag = $urandom_range(1 << 20);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_start_duty();
        case ($urandom_range(3))
            0: return 32'd1;
            1: return 32'd65535;
            2: return 32'd0;
            default: return $urandom_range(65535, 1);
        endcase
    endfunction

    function automatic void pick_levels(output logic [DATA_W-1:0] sp,
                                        output logic [DATA_W-1:0] ms);
        int r;
        int near;
        r = $urandom_range(99);
        ms = DATA_W'($urandom_range(65535));
        if (r < 70) begin
            near = $urandom_range(8192);
            near = near - 4096 + int'(ms);
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            sp = near[DATA_W-1:0];
        end else if (r < 90) begin
            sp = DATA_W'($urandom_range(65535));
        end else begin
            sp = $urandom_range(1) ? '1 : '0;
            ms = $urandom_range(1) ? '1 : '0;
        end
    endfunction

    task automatic report_mismatch(input string line);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("tb: update %0d: %s", ticks_checked, line);
    endtask

    task automatic take_result();
        t_result want;
        if (duty_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result duty %0d", o_duty));
        end else begin
            want = duty_results_due.pop_front();
            if (o_duty !== want.duty)
                report_mismatch($sformatf("duty %0d, expected %0d", o_duty, want.duty));
            if (o_accepted !== want.accepted)
                report_mismatch($sformatf("accepted %0d, expected %0d",
                                          o_accepted, want.accepted));
            if (o_increment !== want.increment)
                report_mismatch($sformatf("increment %0d, expected %0d",
                                          o_increment, want.increment));
            if (want.accepted) taken++;
            else refused++;
            if (want.increment == 32'sh7FFF_FFFF || want.increment == 32'sh8000_0000)
                at_limit++;
        end
        ticks_checked++;
    endtask

    task automatic send_tick(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] ms,
                             input bit typed, input t_result want);
        t_result predicted;
        int      gap;
        gap = steady ? 0 : pick_gap();
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        do @(posedge i_clk); while (full);
        predicted = next_duty_result(sp, ms);
        duty_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_GAIN_CURRENT:         gain_cur = val;
            CFG_GAIN_PREVIOUS:        gain_prev = val;
            CFG_GAIN_BEFORE_PREVIOUS: gain_prev2 = val;
            CFG_START_DUTY:           start_duty_shadow = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_updates();
        push <= 1'b0;
        do @(posedge i_clk); while (duty_results_due.size() != 0);
    endtask

    initial begin : result_side
        int gap_left;
        int held_cycles;
        bit held;
        gap_left = 0;
        held = 1'b0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                take_result();
                gap_left = steady ? 0 : pick_gap();
            end
            if (hold_off_wanted && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_OFF_CYCLES; held_cycles++)
                    @(posedge i_clk);
            end else if (gap_left > 0) begin
                gap_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int                phase;
        int                n;
        bit                after_tick;
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] ms;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_setpoint <= '0;
        i_measured <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GAIN_CURRENT;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        after_tick = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                if (after_tick) drain_updates();
                after_tick = 1'b0;
                write_reg(rows[i].reg_index, rows[i].value);
            end else begin
                send_tick(rows[i].value[31:16], rows[i].value[15:0], rows[i].typed,
                          rows[i].want);
                after_tick = 1'b1;
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_updates();
            write_reg(CFG_GAIN_CURRENT, pick_gain());
            write_reg(CFG_GAIN_PREVIOUS, pick_gain());
            write_reg(CFG_GAIN_BEFORE_PREVIOUS, pick_gain());
            if ($urandom_range(1)) write_reg(CFG_START_DUTY, pick_start_duty());
            steady = (phase % 4 == 1) || (phase == 3);
            // The receiver stalls for a long stretch here while ticks keep coming.
            if (phase == 3) hold_off_wanted = 1'b1;
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                pick_levels(sp, ms);
                send_tick(sp, ms, 1'b0, '0);
            end
        end
        drain_updates();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d duty updates checked, %0d taken, %0d refused, %0d at a limit",
                 ticks_checked, taken, refused, at_limit);
        $display("tb: %0d register writes over %0d gain settings, with one long stall",
                 reg_writes, RANDOM_PHASES + 4);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("tb: timed out with %0d updates outstanding", duty_results_due.size());
        $display("tb: errors");
        $finish;
    end

endmodule
